[rtl/arma_pkg.sv]
package arma_pkg;

  // Accumulator: 30 fractional bits, wide enough for bias plus seven products.
  localparam int ACC_W  = 50;
  localparam int PROD_W = 48;
  localparam int FRAC_SHIFT = 14;
  localparam int FF_ALIGN   = 8;
  localparam int RND_W  = ACC_W - FRAC_SHIFT;

  // History memories: four entries, three of them live.
  localparam int HADDR_W = 2;

  // Tap sequence: ff0..ff3 then fb1..fb3.
  localparam logic [2:0] FIRST_FB_TAP = 3'd4;
  localparam logic [2:0] LAST_TAP     = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FF0  = 3'd0;
  localparam logic [2:0] CFG_FF1  = 3'd1;
  localparam logic [2:0] CFG_FF2  = 3'd2;
  localparam logic [2:0] CFG_FF3  = 3'd3;
  localparam logic [2:0] CFG_BIAS = 3'd4;
  localparam logic [2:0] CFG_FB1  = 3'd5;
  localparam logic [2:0] CFG_FB2  = 3'd6;
  localparam logic [2:0] CFG_FB3  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ISSUE  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic load;   // start of a word: load bias into the accumulator
    logic vld;    // operand and coefficient carry a tap this cycle
    logic is_ff;  // feed-forward tap, needs alignment by FF_ALIGN
  } mac_op_t;

endpackage

[rtl/arma_if.sv]
interface arma_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface arma_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;
  logic               saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

[rtl/arma_iir_filter_step.sv]
// Fixed-point ARMA (direct-form IIR) step. Each input word carries one Q8.8 sample x(t) and
// yields one output word y(t) = bias + sum ff_coef_i*x(t-i) + sum fb_coef_j*y(t-j), in Q16.16,
// rounded to nearest (ties up) and saturated to 32 bits with the saturated flag set on clipping.
// One shared 16x32 multiplier with a registered product and a 50-bit accumulator walks seven taps
// (ff0..ff3, fb1..fb3) one per cycle; past inputs and outputs live in two small synchronous
// history memories that are read one tap ahead and written once per word. A word is accepted
// in the idle state, its seven taps are issued, and the finish state then waits for the read,
// multiply and accumulate stages to drain and the output register to be free. Histories read
// as zero after reset. Configuration writes take effect at once and belong between words.
module arma_iir_filter_step
  import arma_pkg::*;
#(
  parameter int FF_TAPS = 4,
  parameter int FB_TAPS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  arma_in_if.sink     in_ch,
  arma_out_if.source  out_ch
);

  // Configuration registers.
  logic signed [15:0] ff_coef [4];
  logic signed [15:0] fb_coef [1:3];
  logic signed [31:0] bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) ff_coef[i] <= '0;
      for (int j = 1; j <= 3; j++) fb_coef[j] <= '0;
      bias <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FF0:  ff_coef[0] <= cfg_data[15:0];
        CFG_FF1:  ff_coef[1] <= cfg_data[15:0];
        CFG_FF2:  ff_coef[2] <= cfg_data[15:0];
        CFG_FF3:  ff_coef[3] <= cfg_data[15:0];
        CFG_BIAS: bias       <= cfg_data;
        CFG_FB1:  fb_coef[1] <= cfg_data[15:0];
        CFG_FB2:  fb_coef[2] <= cfg_data[15:0];
        CFG_FB3:  fb_coef[3] <= cfg_data[15:0];
        default:  ;
      endcase
    end
  end

  // Sequencer.
  state_t             state;
  logic [2:0]         tap;
  logic [HADDR_W-1:0] head;      // slot where the current word goes; older words sit below it
  logic signed [15:0] x_cur;

  // Stage B: memory data arrives, coefficient waits alongside it.
  logic               b_vld;
  logic               b_is_ff;
  logic               b_tap0;
  logic signed [15:0] b_coef;

  logic               in_acc;
  logic               done;
  logic               out_vld;
  logic signed [31:0] out_sample;
  logic               out_sat;

  logic [2:0]         tap_m3;
  logic [1:0]         fb_j;
  logic [HADDR_W-1:0] x_raddr;
  logic [HADDR_W-1:0] y_raddr;
  logic signed [15:0] issue_coef;
  logic               issue_ff;

  logic [15:0]        x_rd;
  logic [31:0]        y_rd;
  logic signed [31:0] operand;
  mac_op_t            mac_op;
  logic signed [ACC_W-1:0] acc;
  logic               mac_busy;

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RND_W-1:0] rnd;
  logic signed [31:0]      y_new;
  logic                    y_sat;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Finish once the pipe has drained and the output register is free or being emptied.
  assign done = (state == ST_FINISH) && !b_vld && !mac_busy && (!out_vld || out_ch.ready);

  // Address and coefficient for the tap being issued.
  assign tap_m3   = tap - 3'd3;
  assign fb_j     = tap_m3[1:0];
  assign issue_ff = (tap < FIRST_FB_TAP);
  assign x_raddr  = head - HADDR_W'(tap[1:0]);
  assign y_raddr  = head - HADDR_W'(fb_j);

  always_comb begin
    issue_coef = '0;
    if (issue_ff) begin
      if (tap < 3'(FF_TAPS)) begin
        issue_coef = ff_coef[tap[1:0]];
      end
    end else if (fb_j <= 2'(FB_TAPS) && fb_j != 2'd0) begin
      issue_coef = fb_coef[fb_j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
      head  <= '0;
      b_vld <= 1'b0;
    end else begin
      b_vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            tap   <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          b_vld <= 1'b1;
          tap   <= tap + 3'd1;
          if (tap == LAST_TAP) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (done) begin
            head  <= head + HADDR_W'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_cur <= in_ch.sample_in;
    end
    b_is_ff <= issue_ff;
    b_tap0  <= (tap == 3'd0);
    b_coef  <= issue_coef;
  end

  // History memories: x(t-1..t-3) and y(t-1..t-3).
  arma_hist_mem #(.W(16)) u_xhist (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (x_raddr),
    .rd_data (x_rd),
    .wr_en   (done),
    .wr_addr (head),
    .wr_data (x_cur)
  );

  arma_hist_mem #(.W(32)) u_yhist (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (y_raddr),
    .rd_data (y_rd),
    .wr_en   (done),
    .wr_addr (head),
    .wr_data (y_new)
  );

  // Current sample bypasses the memory on tap 0.
  always_comb begin
    if (b_tap0) begin
      operand = 32'(x_cur);
    end else if (b_is_ff) begin
      operand = 32'(signed'(x_rd));
    end else begin
      operand = signed'(y_rd);
    end
  end

  assign mac_op.load  = in_acc;
  assign mac_op.vld   = b_vld;
  assign mac_op.is_ff = b_is_ff;

  arma_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (mac_op),
    .coef    (b_coef),
    .operand (operand),
    .bias    (bias),
    .acc     (acc),
    .busy    (mac_busy)
  );

  // Round half up to Q16.16, then clip to 32 bits.
  assign acc_rnd = acc + ACC_W'(1 << (FRAC_SHIFT - 1));
  assign rnd     = RND_W'(acc_rnd >>> FRAC_SHIFT);

  always_comb begin
    y_sat = 1'b0;
    y_new = rnd[31:0];
    if (rnd > RND_W'(signed'(32'h7fff_ffff))) begin
      y_new = 32'sh7fff_ffff;
      y_sat = 1'b1;
    end else if (rnd < RND_W'(signed'(32'h8000_0000))) begin
      y_new = 32'sh8000_0000;
      y_sat = 1'b1;
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (done) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_sample <= y_new;
      out_sat    <= y_sat;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.sample_out = out_sample;
  assign out_ch.saturated  = out_sat;

  // A word is worked on alone: no second accept right after one.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  // The pipe is empty whenever the sequencer is idle.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!b_vld && !mac_busy))
    else $error("tap pipeline busy while idle");

  // A new result only comes out of the finish step.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state == ST_FINISH))
    else $error("output loaded outside the finish step");

  // Tap counter stays within the seven taps while issuing.
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (tap <= LAST_TAP))
    else $error("tap index out of range");

endmodule

[rtl/arma_hist_mem.sv]
module arma_hist_mem
  import arma_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [HADDR_W-1:0]  rd_addr,
  output logic [W-1:0]        rd_data,
  input  logic                wr_en,
  input  logic [HADDR_W-1:0]  wr_addr,
  input  logic [W-1:0]        wr_data
);

  localparam int DEPTH = 1 << HADDR_W;

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [W-1:0]     q;
  logic             q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q <= mem[rd_addr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      q_vld <= vld[rd_addr];
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule

[rtl/arma_mac.sv]
module arma_mac
  import arma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  input  logic signed [15:0]      coef,
  input  logic signed [31:0]      operand,
  input  logic signed [31:0]      bias,
  output logic signed [ACC_W-1:0] acc,
  output logic                    busy
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_ff;
  logic signed [ACC_W-1:0]  prod_al;

  always_ff @(posedge clk) begin
    prod    <= coef * operand;
    prod_ff <= op.is_ff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= op.vld;
    end
  end

  // Q8.8 x Q2.14 has 22 fraction bits: move up to 30.
  always_comb begin
    prod_al = ACC_W'(prod);
    if (prod_ff) begin
      prod_al = prod_al <<< FF_ALIGN;
    end
  end

  always_ff @(posedge clk) begin
    if (op.load) begin
      acc <= ACC_W'(bias) <<< FRAC_SHIFT;
    end else if (prod_vld) begin
      acc <= acc + prod_al;
    end
  end

  assign busy = prod_vld;

endmodule

[bench/arma_iir_filter_step_tb.sv]
module arma_iir_filter_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arma_pkg::*;

  localparam int FF_TAPS = 4;
  localparam int FB_TAPS = 3;

  // Cycles with no word moving on either channel before the run is declared hung.
  // The slowest legal word adds the longest sender gap and the longest receiver stall to the block's own work.
  localparam int STALL_LIMIT = 2000;

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  localparam logic [2:0] FF_IDX [4] = '{CFG_FF0, CFG_FF1, CFG_FF2, CFG_FF3};
  localparam logic [2:0] FB_IDX [1:3] = '{CFG_FB1, CFG_FB2, CFG_FB3};

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic               saturated;
  } arma_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;

  arma_in_if  in_ch ();
  arma_out_if out_ch ();

  arma_iir_filter_step #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow copy of the filter: coefficients as last written, histories as last predicted.
  logic signed [15:0] ff_coef [4];
  logic signed [15:0] fb_coef [1:3];
  logic signed [31:0] bias_q;
  logic signed [15:0] x_hist [3];
  logic signed [31:0] y_hist [3];

  logic [15:0] samples_to_send [$];
  arma_word_t  expected_outputs [$];

  int samples_queued;
  int outputs_seen;
  int fail_count;
  int in_gap;
  int out_stall;
  int out_draw;
  int quiet_cycles;
  bit in_calm;
  bit out_calm;

  always #4 clk = ~clk;

  // Compute y(t) for a newly accepted sample and advance both histories.
  // Accumulate at 30 fractional bits, round half up to Q16.16, then clip to 32 bits.
  function automatic void predict_arma_output(input logic signed [15:0] x);
    logic signed [15:0] taps [4];
    longint             acc;
    longint             rounded;
    arma_word_t         w;
    taps[0] = x;
    taps[1] = x_hist[0];
    taps[2] = x_hist[1];
    taps[3] = x_hist[2];
    acc = longint'(bias_q) * 16384;
    for (int i = 0; i < FF_TAPS; i++)
      acc += longint'(ff_coef[i]) * longint'(taps[i]) * 256;
    for (int j = 1; j <= FB_TAPS; j++)
      acc += longint'(fb_coef[j]) * longint'(y_hist[j-1]);
    rounded = (acc + 8192) >>> 14;
    if (rounded > Y_MAX) begin
      w.sample_out = 32'sh7fffffff;
      w.saturated  = 1'b1;
    end else if (rounded < Y_MIN) begin
      w.sample_out = 32'sh80000000;
      w.saturated  = 1'b1;
    end else begin
      w.sample_out = rounded[31:0];
      w.saturated  = 1'b0;
    end
    // The clipped value, not the raw sum, feeds back.
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = w.sample_out;
    expected_outputs.push_back(w);
  endfunction

  function automatic void report_failure(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", what);
  endfunction

  function automatic void check_output(input logic signed [31:0] got, input logic got_sat);
    arma_word_t w;
    outputs_seen++;
    if (expected_outputs.size() == 0) begin
      report_failure($sformatf("unexpected output word: out=%0d sat=%0b", got, got_sat));
    end else begin
      w = expected_outputs.pop_front();
      if (got !== w.sample_out || got_sat !== w.saturated)
        report_failure($sformatf(
          "mismatch on output word %0d: expected out=%0d sat=%0b, got out=%0d sat=%0b",
          outputs_seen, w.sample_out, w.saturated, got, got_sat));
    end
  endfunction

  // Per-word wait drawn at random; now and then flip into a run of back-to-back words.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0)
      calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [15:0] pick_coef(input bit tame);
    if (tame)
      return 16'($urandom_range(0, 8191)) - 16'd4096;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom());
    endcase
  endfunction

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_FF0:  ff_coef[0] = data[15:0];
      CFG_FF1:  ff_coef[1] = data[15:0];
      CFG_FF2:  ff_coef[2] = data[15:0];
      CFG_FF3:  ff_coef[3] = data[15:0];
      CFG_BIAS: bias_q     = data;
      CFG_FB1:  fb_coef[1] = data[15:0];
      CFG_FB2:  fb_coef[2] = data[15:0];
      CFG_FB3:  fb_coef[3] = data[15:0];
      default: ;
    endcase
  endtask

  // Load every register; the upper half of a 16-bit register's data is junk on purpose.
  task automatic set_filter(input logic [15:0] ff0, input logic [15:0] ff1,
                            input logic [15:0] ff2, input logic [15:0] ff3,
                            input logic [31:0] bias_val, input logic [15:0] fb1,
                            input logic [15:0] fb2, input logic [15:0] fb3);
    write_reg(FF_IDX[0], {16'($urandom()), ff0});
    write_reg(FF_IDX[1], {16'($urandom()), ff1});
    write_reg(FF_IDX[2], {16'($urandom()), ff2});
    write_reg(FF_IDX[3], {16'($urandom()), ff3});
    write_reg(CFG_BIAS, bias_val);
    write_reg(FB_IDX[1], {16'($urandom()), fb1});
    write_reg(FB_IDX[2], {16'($urandom()), fb2});
    write_reg(FB_IDX[3], {16'($urandom()), fb3});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly stable settings; some phases drive the output into the rails on purpose.
  task automatic random_setting();
    int          style;
    logic [31:0] bias_pick;
    logic [15:0] fb_pick [1:3];
    style = $urandom_range(0, 3);
    if ($urandom_range(0, 1) != 0)
      bias_pick = $urandom();
    else
      bias_pick = 32'($urandom_range(0, 262143)) - 32'd131072;
    for (int j = 1; j <= 3; j++)
      fb_pick[j] = (style == 0) ? 16'd0 : pick_coef(style != 3);
    set_filter(pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0),
               bias_pick, fb_pick[1], fb_pick[2], fb_pick[3]);
  endtask

  task automatic queue_sample(input logic [15:0] x);
    samples_to_send.push_back(x);
    samples_queued++;
  endtask

  // Hold until every queued word has come back out.
  task automatic drain();
    while (outputs_seen < samples_queued)
      @(posedge clk);
  endtask

  // Sender: present one word at a time, hold it until taken, then idle for a drawn
  // number of cycles in which the block is ready, so that the gap is actually seen.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.sample_in <= '0;
      in_gap          <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_arma_output(in_ch.sample_in);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the word
      end else if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        if (in_ch.ready && !in_ch.valid)
          in_gap <= in_gap - 1;
      end else if (samples_to_send.size() != 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= samples_to_send.pop_front();
        in_gap          <= draw_wait(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: after each word, stall for a drawn number of cycles in which a word waits,
  // so that backpressure lands on the block's output stage.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      check_output(out_ch.sample_out, out_ch.saturated);
      out_draw = draw_wait(out_calm);
      out_stall    <= out_draw;
      out_ch.ready <= (out_draw == 0);
    end else if (out_ch.valid && out_stall != 0) begin
      out_stall    <= out_stall - 1;
      out_ch.ready <= (out_stall == 1);
    end else begin
      out_ch.ready <= (out_stall == 0);
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("arma_iir_filter_step_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_FF0;
    cfg_data        = '0;
    samples_queued  = 0;
    outputs_seen    = 0;
    fail_count      = 0;
    bias_q          = '0;
    for (int i = 0; i < 4; i++)
      ff_coef[i] = '0;
    for (int j = 1; j <= 3; j++)
      fb_coef[j] = '0;
    for (int k = 0; k < 3; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: all coefficients and bias zero, so the output stays zero.
    queue_sample(16'h7fff);
    queue_sample(16'h8000);
    drain();

    // Feed-forward only, coefficients at their extremes and unity on the current tap.
    set_filter(16'h4000, 16'h8000, 16'h7fff, 16'h0001, 32'h0000_0001,
               16'h0000, 16'h0000, 16'h0000);
    queue_sample(16'h7fff);
    queue_sample(16'h8000);
    queue_sample(16'h0001);
    queue_sample(16'hffff);
    queue_sample(16'h0020);
    drain();

    // Smallest coefficient on x(t): +/-32 lands exactly on a half LSB, ties round up;
    // +/-96 is one and a half LSB.
    set_filter(16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
               16'h0000, 16'h0000, 16'h0000);
    queue_sample(16'h0020);
    queue_sample(16'hffe0);
    queue_sample(16'h0060);
    queue_sample(16'hffa0);
    drain();

    // Maximum bias and strong positive feedback: clip at the top, clipped value fed back.
    set_filter(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 32'h7fff_ffff,
               16'h7fff, 16'h8000, 16'h7fff);
    queue_sample(16'h7fff);
    queue_sample(16'h7fff);
    queue_sample(16'h7fff);
    queue_sample(16'h8000);
    drain();

    // Minimum bias: clip at the bottom.
    set_filter(16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000,
               16'h7fff, 16'h0000, 16'h0000);
    queue_sample(16'h7fff);
    queue_sample(16'h7fff);
    queue_sample(16'h0000);
    queue_sample(16'h8000);
    drain();

    // Negative unity feedback on a history that sits at the bottom rail.
    set_filter(16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
               16'hc000, 16'h2000, 16'h0000);
    queue_sample(16'h0100);
    queue_sample(16'hff00);
    queue_sample(16'h0000);
    queue_sample(16'h0000);
    drain();

    // Random phases: new settings between phases, random samples within.
    for (int p = 0; p < 12; p++) begin
      random_setting();
      n = $urandom_range(120, 180);
      for (int i = 0; i < n; i++)
        queue_sample(pick_sample());
      drain();
    end

    repeat (16) @(posedge clk);
    if (expected_outputs.size() != 0)
      report_failure($sformatf("%0d expected output words never arrived",
                               expected_outputs.size()));
    if (fail_count == 0) begin
      $display("arma_iir_filter_step_tb OK");
    end else begin
      $display("arma_iir_filter_step_tb NOT OK");
    end
    $finish;
  end

endmodule
